// ===== rtl/core/modbus_rtu_request_framer_defines.svh =====
// Assertion macros for the Modbus RTU request framer.
// Standalone header; no dependencies. Bodies drop out when SYNTH is defined.
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define MRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");
// Antecedent implies consequent in the next cycle.
`define MRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");
`else
`define MRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/mrf_pkg.sv =====
// Shared constants, types and the CRC-16 byte update for the request framer.
// No dependencies.
package mrf_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned BODY_BYTES  = 6;
  localparam int unsigned BODY_W      = 8 * BODY_BYTES;
  localparam int unsigned FRAME_W     = 8 * FRAME_BYTES;
  localparam int unsigned BEAT_W      = $clog2(FRAME_BYTES);

  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BYTES - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] COIL_ON_BYTE  = 8'hFF;
  localparam logic [7:0] COIL_OFF_BYTE = 8'h00;

  localparam logic FUNC_WORD = 1'b0;
  localparam logic FUNC_COIL = 1'b1;

  typedef logic [BODY_W-1:0] body_t;

  typedef struct packed {
    logic        valid;
    body_t       body;
    logic [15:0] crc;
  } frame_t;

  // One byte of reflected CRC-16 (poly 0xA001).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ===== rtl/core/mrf_req_if.sv =====
// Request channel: valid/ready handshake plus one request per beat.
// No dependencies.
interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  dev_addr;
  logic [7:0]  fn_code;
  logic [15:0] reg_addr;
  logic [15:0] word_value;
  logic        coil_on;

  modport source (output valid, func, dev_addr, fn_code, reg_addr,
                  word_value, coil_on, input ready);
  modport sink   (input valid, func, dev_addr, fn_code, reg_addr,
                  word_value, coil_on, output ready);
endinterface

// ===== rtl/core/mrf_byte_if.sv =====
// Frame byte channel: valid/ready handshake plus one frame byte per beat.
// No dependencies.
interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, frame_byte, last, input ready);
  modport sink   (input valid, frame_byte, last, output ready);
endinterface

// ===== rtl/core/mrf_crc_pipe.sv =====
// Six-stage CRC pipeline: builds the frame body and folds one body byte per stage.
// Depends on mrf_pkg and mrf_req_if.
module mrf_crc_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  mrf_req_if.sink         req_i,
  output mrf_pkg::frame_t frame_o,
  input  logic            frame_ready_i
);
  import mrf_pkg::*;

  localparam int unsigned NSTG = BODY_BYTES;

  logic        vld_q  [NSTG];
  body_t       body_q [NSTG];
  logic [15:0] crc_q  [NSTG];

  logic        advance;
  body_t       body_d;
  logic [7:0]  val_hi;
  logic [7:0]  val_lo;

  // The whole pipe moves together; an empty tail lets it move under stall.
  assign advance     = !vld_q[NSTG-1] || frame_ready_i;
  assign req_i.ready = advance;

  always_comb begin
    if (req_i.func == FUNC_COIL) begin
      val_hi = req_i.coil_on ? COIL_ON_BYTE : COIL_OFF_BYTE;
      val_lo = COIL_OFF_BYTE;
    end else begin
      val_hi = req_i.word_value[15:8];
      val_lo = req_i.word_value[7:0];
    end
    body_d = {req_i.dev_addr, req_i.fn_code, req_i.reg_addr, val_hi, val_lo};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) vld_q[s] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= req_i.valid;
      for (int s = 1; s < NSTG; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Stage s folds body byte s (slave id sits in the top byte).
  always_ff @(posedge clk_i) begin
    if (advance) begin
      body_q[0] <= body_d;
      crc_q[0]  <= crc_byte(CRC_INIT, req_i.dev_addr);
      for (int s = 1; s < NSTG; s++) begin
        body_q[s] <= body_q[s-1];
        crc_q[s]  <= crc_byte(crc_q[s-1], body_q[s-1][8*(BODY_BYTES-1-s) +: 8]);
      end
    end
  end

  assign frame_o.valid = vld_q[NSTG-1];
  assign frame_o.body  = body_q[NSTG-1];
  assign frame_o.crc   = crc_q[NSTG-1];

endmodule

// ===== rtl/core/modbus_rtu_request_framer.sv =====
// Modbus RTU request framer: request in, 8-byte RTU frame out, one byte per beat.
// A request passes through the six CRC stages and then loads the output register, from which
// the first frame byte leaves. Request throughput is set by the byte-wide output channel.
// The CRC pipe keeps taking requests while a frame drains, until a finished frame waits at its tail.
// Reset (rst_ni, async, active low) empties the pipe and the output register.
// Depends on mrf_pkg, mrf_req_if, mrf_byte_if, mrf_crc_pipe and the defines header.
`include "modbus_rtu_request_framer_defines.svh"

module modbus_rtu_request_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrf_req_if.sink    req_i,
  mrf_byte_if.source frame_o
);
  import mrf_pkg::*;

  // Finished frame from the CRC pipe, plus its back-pressure.
  frame_t pipe_frame;
  logic   pipe_ready;
  logic   pipe_vld;

  mrf_crc_pipe u_crc_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .frame_o       (pipe_frame),
    .frame_ready_i (pipe_ready)
  );

  assign pipe_vld = pipe_frame.valid;

  // Output register: the whole frame shifts out top byte first.
  logic               out_vld_q, out_vld_d;
  logic [BEAT_W-1:0]  cnt_q, cnt_d;
  logic [BEAT_W-1:0]  cnt_inc;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               beat_acc;
  logic               last_acc;
  logic               mid_acc;

  assign beat_acc = out_vld_q && frame_o.ready;
  assign last_acc = beat_acc && (cnt_q == LAST_BEAT);
  assign mid_acc  = beat_acc && (cnt_q != LAST_BEAT);
  assign cnt_inc  = cnt_q + BEAT_W'(1);

  // Free when empty, or when the last beat of the current frame leaves now.
  assign pipe_ready = !out_vld_q || last_acc;

  always_comb begin
    out_vld_d = out_vld_q;
    cnt_d     = cnt_q;
    frame_d   = frame_q;
    if (pipe_ready) begin
      // Load the next frame (or go empty); CRC goes low byte first.
      out_vld_d = pipe_vld;
      cnt_d     = '0;
      frame_d   = {pipe_frame.body, pipe_frame.crc[7:0], pipe_frame.crc[15:8]};
    end else if (mid_acc) begin
      // Advance to the next byte.
      cnt_d   = cnt_inc;
      frame_d = {frame_q[FRAME_W-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign frame_o.valid      = out_vld_q;
  assign frame_o.frame_byte = frame_q[FRAME_W-1 -: 8];
  assign frame_o.last       = (cnt_q == LAST_BEAT);

  // A mid-frame beat moves to the next byte and keeps the frame going.
  `MRF_ASSERT_NEXT(a_mid_beat_advances, clk_i, rst_ni, mid_acc, out_vld_q && cnt_q == $past(cnt_inc))
  // After the last beat the output valid follows what the pipe offered and the count restarts at zero.
  `MRF_ASSERT_NEXT(a_last_beat_reloads, clk_i, rst_ni, last_acc, out_vld_q == $past(pipe_vld) && ~|cnt_q)
  // A finished frame the output cannot take stays in the pipe.
  `MRF_ASSERT_NEXT(a_pipe_holds_on_stall, clk_i, rst_ni, pipe_vld && !pipe_ready, $stable(pipe_frame))
  // A frame never starts mid-stream: a fresh load always begins at byte zero.
  `MRF_ASSERT_SAME(a_idle_count_zero, clk_i, rst_ni, !out_vld_q, cnt_q == '0)

endmodule
